>>> design/chm_pkg.sv
// shared types and constants for the chained hash map
package chm_pkg;
	localparam int MAX_BUCKETS_DEF = 256;
	localparam int POOL_ENTRIES_DEF = 1024;
	localparam logic [31:0] HASH_MUL = 32'd2654435761;

	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_FIND   = 2'd1,
		MODE_REMOVE = 2'd2,
		MODE_NOP    = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL     = 2'd2
	} status_t;
endpackage

>>> design/chm_front.sv
// front end: accepts transactions, hashes the key and reduces it to a bucket
module chm_front #(
	parameter int MAX_BUCKETS = chm_pkg::MAX_BUCKETS_DEF,
	parameter int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1,
	parameter int CW = $clog2(MAX_BUCKETS + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [1:0]    mode,
	input  logic [31:0]   key,
	input  logic [31:0]   value,
	input  logic [CW-1:0] count,
	output logic          q_valid,
	input  logic          q_stall,
	output logic [1:0]    q_mode,
	output logic [31:0]   q_key,
	output logic [31:0]   q_value,
	output logic [BW-1:0] q_bucket
);
	// hash register, then a restoring remainder one bit per cycle
	logic        busy_q;
	logic [5:0]  step_q;
	logic [31:0] h_q;
	logic [CW:0] rem_q;
	logic [1:0]  mode_q;
	logic [31:0] key_q, value_q;
	logic        done_q;
	logic [31:0] prod;
	logic [CW:0] trial;

	// only the low 32 bits of the product are used
	assign prod = key * chm_pkg::HASH_MUL;
	assign trial = {rem_q[CW-1:0], h_q[31]};
	assign in_stall = busy_q || done_q;
	assign q_valid = done_q;
	assign q_mode = mode_q;
	assign q_key = key_q;
	assign q_value = value_q;
	assign q_bucket = rem_q[BW-1:0];

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			h_q <= prod;
			rem_q <= '0;
			mode_q <= mode;
			key_q <= key;
			value_q <= value;
		end else if (busy_q) begin
			h_q <= {h_q[30:0], 1'b0};
			if (trial >= {1'b0, count}) rem_q <= trial - {1'b0, count};
			else rem_q <= trial;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 6'd1;
				if (step_q == 6'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (done_q && !q_stall) begin
				done_q <= 1'b0;
			end
		end
	end
endmodule

>>> design/chm_queue.sv
// two-entry queue between front and back ends
module chm_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_valid,
	output logic         wr_stall,
	input  logic [W-1:0] wr_data,
	output logic         rd_valid,
	input  logic         rd_stall,
	output logic [W-1:0] rd_data
);
	logic [W-1:0] mem_q [2];
	logic         wp_q, rp_q;
	logic [1:0]   cnt_q;
	logic         wr, rd;

	assign wr = wr_valid && !wr_stall;
	assign rd = rd_valid && !rd_stall;
	assign wr_stall = cnt_q == 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= !wp_q;
			if (rd) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end
endmodule

>>> design/chm_back.sv
// back end: chain walk, insert and remove over the entry memories
module chm_back #(
	parameter int MAX_BUCKETS = chm_pkg::MAX_BUCKETS_DEF,
	parameter int POOL_ENTRIES = chm_pkg::POOL_ENTRIES_DEF,
	parameter int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1,
	parameter int EW = $clog2(POOL_ENTRIES + 1),
	parameter int AW = $clog2(POOL_ENTRIES)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	output logic          q_stall,
	input  logic [1:0]    q_mode,
	input  logic [31:0]   q_key,
	input  logic [31:0]   q_value,
	input  logic [BW-1:0] q_bucket,
	output logic          out_valid,
	input  logic          out_stall,
	output logic          found,
	output logic [31:0]   read_value,
	output logic [1:0]    status
);
	localparam logic [EW-1:0] NULL_E = EW'(POOL_ENTRIES);

	typedef enum logic [3:0] {
		B_IDLE, B_HEAD, B_ALLOC, B_FREE_RD, B_INS, B_RD, B_CMP, B_UNLINK, B_OUT
	} bstate_t;

	// memories: heads, keys, values, links; heads cleared by a sweep after reset
	logic [EW-1:0] heads_m [MAX_BUCKETS];
	logic [31:0]   keys_m  [POOL_ENTRIES];
	logic [31:0]   vals_m  [POOL_ENTRIES];
	logic [EW-1:0] links_m [POOL_ENTRIES];

	bstate_t st_q, st_d;
	logic [BW:0]   clr_q;
	logic          clr_done;
	logic [EW-1:0] fresh_q, free_q, cur_q, prev_q, head_rd_q, link_rd_q;
	logic [31:0]   key_rd_q, val_rd_q;
	logic [EW:0]   steps_q;
	logic          found_q;
	logic [31:0]  rval_q;
	logic [1:0]    stat_q;
	logic [BW-1:0] q_bucket_r;
	logic [1:0]    mode_r;
	logic [31:0]   key_r, value_r;
	logic [EW-1:0] alloc_e;

	assign clr_done = clr_q[BW] || (clr_q == (BW+1)'(MAX_BUCKETS));
	assign q_stall = !(st_q == B_IDLE && clr_done);
	assign out_valid = st_q == B_OUT;
	assign found = found_q;
	assign read_value = rval_q;
	assign status = stat_q;

	function automatic logic ent_ok(input logic [EW-1:0] e);
		ent_ok = e < NULL_E;
	endfunction

	// registered memory reads; the head is fetched with the incoming bucket
	always_ff @(posedge clk) begin
		head_rd_q <= heads_m[(st_q == B_IDLE) ? q_bucket : q_bucket_r];
		key_rd_q  <= keys_m[cur_q[AW-1:0]];
		val_rd_q  <= vals_m[cur_q[AW-1:0]];
		link_rd_q <= links_m[cur_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (st_q == B_IDLE && q_valid && clr_done) begin
			q_bucket_r <= q_bucket;
			mode_r <= q_mode;
			key_r <= q_key;
			value_r <= q_value;
		end
	end

	// head memory write port
	always_ff @(posedge clk) begin
		if (!clr_done) heads_m[clr_q[BW-1:0]] <= NULL_E;
		else if (st_q == B_INS) heads_m[q_bucket_r] <= alloc_e;
		else if (st_q == B_UNLINK && !ent_ok(prev_q)) heads_m[q_bucket_r] <= link_rd_q;
	end

	// entry memory writes
	always_ff @(posedge clk) begin
		if (st_q == B_INS) begin
			keys_m[alloc_e[AW-1:0]] <= key_r;
			vals_m[alloc_e[AW-1:0]] <= value_r;
		end
	end

	logic          lw_en;
	logic [EW-1:0] lw_addr, lw_data;
	logic [1:0]    ul_q;
	always_comb begin
		lw_en = 1'b0;
		lw_addr = cur_q;
		lw_data = head_rd_q;
		if (st_q == B_INS) begin
			lw_en = 1'b1;
			lw_addr = alloc_e;
			lw_data = head_rd_q;
		end else if (st_q == B_UNLINK && ul_q == 2'd0) begin
			lw_en = ent_ok(prev_q);
			lw_addr = prev_q;
			lw_data = link_rd_q;
		end else if (st_q == B_UNLINK && ul_q == 2'd1) begin
			lw_en = 1'b1;
			lw_addr = cur_q;
			lw_data = free_q;
		end
	end
	always_ff @(posedge clk) begin
		if (lw_en) links_m[lw_addr[AW-1:0]] <= lw_data;
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			B_IDLE: if (q_valid && clr_done) st_d = B_HEAD;
			B_HEAD: begin
				if (mode_r == chm_pkg::MODE_INSERT) st_d = B_ALLOC;
				else if (mode_r == chm_pkg::MODE_NOP) st_d = B_OUT;
				else st_d = B_RD;
			end
			B_ALLOC: begin
				if (ent_ok(free_q)) st_d = B_FREE_RD;
				else if (fresh_q < NULL_E) st_d = B_INS;
				else st_d = B_OUT;
			end
			B_FREE_RD: st_d = B_INS;
			B_INS: st_d = B_OUT;
			B_RD: begin
				if (!ent_ok(cur_q) || steps_q >= (EW+1)'(POOL_ENTRIES)) st_d = B_OUT;
				else st_d = B_CMP;
			end
			B_CMP: begin
				if (key_rd_q == key_r) st_d = (mode_r == chm_pkg::MODE_REMOVE) ? B_UNLINK : B_OUT;
				else st_d = B_RD;
			end
			B_UNLINK: if (ul_q == 2'd1) st_d = B_OUT;
			B_OUT: if (!out_stall) st_d = B_IDLE;
			default: st_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= B_IDLE;
			clr_q <= '0;
			fresh_q <= '0;
			free_q <= NULL_E;
			cur_q <= NULL_E;
			prev_q <= NULL_E;
			steps_q <= '0;
			alloc_e <= NULL_E;
			ul_q <= '0;
			found_q <= 1'b0;
			rval_q <= '0;
			stat_q <= chm_pkg::ST_OK;
		end else begin
			st_q <= st_d;
			if (!clr_done) clr_q <= clr_q + 1'b1;
			case (st_q)
				B_IDLE: begin
					found_q <= 1'b0;
					rval_q <= '0;
					stat_q <= chm_pkg::ST_OK;
					steps_q <= '0;
					ul_q <= '0;
					prev_q <= NULL_E;
				end
				B_HEAD: begin
					// head_rd_q valid now; start chain walk from it
					cur_q <= head_rd_q;
					if (mode_r == chm_pkg::MODE_FIND || mode_r == chm_pkg::MODE_REMOVE)
						stat_q <= chm_pkg::ST_NOT_FOUND;
				end
				B_ALLOC: begin
					if (ent_ok(free_q)) begin
						alloc_e <= free_q;
						cur_q <= free_q;
					end else if (fresh_q < NULL_E) begin
						alloc_e <= fresh_q;
						fresh_q <= fresh_q + 1'b1;
					end else begin
						stat_q <= chm_pkg::ST_FULL;
					end
				end
				B_FREE_RD: ;
				B_INS: if (alloc_e == free_q) free_q <= link_rd_q;
				B_RD: ;
				B_CMP: begin
					if (key_rd_q == key_r) begin
						found_q <= 1'b1;
						stat_q <= chm_pkg::ST_OK;
						if (mode_r == chm_pkg::MODE_FIND) rval_q <= val_rd_q;
					end else begin
						prev_q <= cur_q;
						cur_q <= link_rd_q;
						steps_q <= steps_q + 1'b1;
					end
				end
				B_UNLINK: begin
					ul_q <= ul_q + 2'd1;
					if (ul_q == 2'd1) free_q <= cur_q;
				end
				default: ;
			endcase
		end
	end
endmodule

>>> design/chained_hash_map_u32.sv
// Chained hash map with 32-bit keys and values over a fixed entry pool. An
// item passes through the front end (a multiplicative hash register, then a
// bit-serial remainder by bucket_count, then a hand-off) and, in the back end,
// through a chain walk for a find or a remove, where a remove hit also
// unlinks the entry; an insert takes a freed entry if there is one, else a
// fresh entry, and reports full when the pool is exhausted. The front end
// takes no new item until the last is handed off. Front and back run
// concurrently through a two-entry queue, so throughput is set by the slower
// of the two, normally the remainder unit. After reset the bucket head memory
// is swept to empty before the back end takes its first item.
module chained_hash_map_u32 #(
	parameter int MAX_BUCKETS = chm_pkg::MAX_BUCKETS_DEF,
	parameter int POOL_ENTRIES = chm_pkg::POOL_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [31:0] key,
	input  logic [31:0] value,
	input  logic        cfg_we,
	input  logic [8:0]  cfg_wdata,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        found,
	output logic [31:0] read_value,
	output logic [1:0]  status
);
	localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
	localparam int CW = $clog2(MAX_BUCKETS + 1);
	localparam int QW = 2 + 32 + 32 + BW;
	localparam int RST_CNT = (MAX_BUCKETS < 256) ? MAX_BUCKETS : 256;

	logic [CW-1:0] count_q;
	logic          f_valid, f_stall, b_valid, b_stall;
	logic [1:0]    f_mode;
	logic [31:0]   f_key, f_value;
	logic [BW-1:0] f_bucket;
	logic [QW-1:0] b_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) count_q <= CW'(RST_CNT);
		else if (cfg_we) begin
			if (cfg_wdata == 9'd0) count_q <= CW'(1);
			else if (32'(cfg_wdata) > 32'(MAX_BUCKETS)) count_q <= CW'(MAX_BUCKETS);
			else count_q <= CW'(cfg_wdata);
		end
	end

	chm_front #(.MAX_BUCKETS(MAX_BUCKETS)) u_front (
		.clk, .arst_n, .in_valid, .in_stall, .mode, .key, .value,
		.count(count_q), .q_valid(f_valid), .q_stall(f_stall),
		.q_mode(f_mode), .q_key(f_key), .q_value(f_value), .q_bucket(f_bucket)
	);

	chm_queue #(.W(QW)) u_queue (
		.clk, .arst_n, .wr_valid(f_valid), .wr_stall(f_stall),
		.wr_data({f_mode, f_key, f_value, f_bucket}),
		.rd_valid(b_valid), .rd_stall(b_stall), .rd_data(b_data)
	);

	chm_back #(.MAX_BUCKETS(MAX_BUCKETS), .POOL_ENTRIES(POOL_ENTRIES)) u_back (
		.clk, .arst_n, .q_valid(b_valid), .q_stall(b_stall),
		.q_mode(b_data[QW-1 -: 2]), .q_key(b_data[QW-3 -: 32]),
		.q_value(b_data[BW+31 -: 32]), .q_bucket(b_data[BW-1:0]),
		.out_valid, .out_stall, .found, .read_value, .status
	);
endmodule
